// ===== hdl/slcd_pkg.sv =====
// slcd_pkg: types and constants of the sync/length/checksum deframer
// no dependencies; imported by the deframer unit and its testbench

package slcd_pkg;

  // most words one frame may produce
  localparam int unsigned MaxResults = 16;

  // header bytes between the sync byte and the checksum byte
  localparam int unsigned HeaderBytes = 2;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_CHECK,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_READ,
    PH_CAPT,
    PH_PUSH
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WORD     = 2'd0,
    KIND_ORDER    = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_e;

endpackage

// ===== hdl/slcd_ram.sv =====
// slcd_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module slcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/sync_length_checksum_deframer_unit.sv =====
// sync_length_checksum_deframer_unit: byte-stream frame hunter, checksum check, word/order/oversize output
// depends on slcd_pkg and slcd_ram (payload store)
// throughput: one input byte per cycle during a frame; the length byte waits for a free output
// oversize: the beat is loaded into the output register when the length byte is accepted
// a passing frame is read out of the payload ram: each byte is read (PH_READ) and captured
// (PH_CAPT), four bytes per word or two for an order pair, then PH_PUSH loads the output beat
// once the output is free; no byte is taken while the payload ram is being read out
// reset: async active low; phase hunts, sync byte is 0, payload ram is not cleared

module sync_length_checksum_deframer_unit
  import slcd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] data_word_o,
  output logic [7:0]  order_first_o,
  output logic [7:0]  order_second_o,
  output logic        last_o
);

  localparam int unsigned AddrW = $clog2(MAX_PAYLOAD_BYTES);
  localparam int unsigned WcntW = $clog2(MaxResults + 1);

  phase_e           phase_q, phase_d;
  logic [7:0]       sync_q;
  logic             hdr_cnt_q, hdr_cnt_d;
  logic [7:0]       exp_q, exp_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       taken_q, taken_d;
  logic             order_q, order_d;
  logic [WcntW-1:0] words_left_q, words_left_d;
  logic [AddrW-1:0] byte_idx_q, byte_idx_d;
  logic [1:0]       grp_q, grp_d;
  logic [31:0]      asm_q, asm_d;

  logic             out_valid_q;
  kind_e            kind_q, kind_d;
  logic [31:0]      word_q, word_d;
  logic [7:0]       first_q, first_d, second_q, second_d;
  logic             last_q, last_d;
  logic             out_load;
  logic             out_free;

  logic             in_acc;
  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata;
  logic [7:0]       sum_next;
  logic [7:0]       taken_next;
  logic [5:0]       len_words;
  logic [WcntW-1:0] words_cap;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign sum_next   = sum_q + in_byte_i;
  assign taken_next = taken_q + 8'd1;
  assign len_words  = len_q[7:2];
  assign words_cap  = (len_words > 6'(MaxResults)) ? WcntW'(MaxResults)
                                                    : WcntW'(len_words);

  slcd_ram #(
    .Width(8),
    .Depth(MAX_PAYLOAD_BYTES)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(taken_q[AddrW-1:0]),
    .wdata_i(in_byte_i),
    .re_i   (ram_re),
    .raddr_i(byte_idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    exp_d        = exp_q;
    len_d        = len_q;
    sum_d        = sum_q;
    taken_d      = taken_q;
    order_d      = order_q;
    words_left_d = words_left_q;
    byte_idx_d   = byte_idx_q;
    grp_d        = grp_q;
    asm_d        = asm_q;
    kind_d       = kind_q;
    word_d       = word_q;
    first_d      = first_q;
    second_d     = second_q;
    last_d       = last_q;
    out_load     = 1'b0;
    in_ready_o   = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    unique case (phase_q)
      PH_HUNT: begin
        in_ready_o = 1'b1;
        if (in_acc && in_byte_i == sync_q) begin
          phase_d   = PH_HEADER;
          hdr_cnt_d = 1'b0;
        end
      end
      PH_HEADER: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          hdr_cnt_d = 1'b1;
          if (hdr_cnt_q == 1'(HeaderBytes - 1)) begin
            phase_d = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          exp_d   = in_byte_i;
          phase_d = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        // an oversize length loads a beat straight away
        in_ready_o = out_free;
        if (in_acc) begin
          len_d   = in_byte_i;
          sum_d   = in_byte_i;
          taken_d = '0;
          if (in_byte_i > 8'(MAX_PAYLOAD_BYTES)) begin
            phase_d  = PH_HUNT;
            out_load = 1'b1;
            kind_d   = KIND_OVERSIZE;
            word_d   = '0;
            first_d  = '0;
            second_d = '0;
            last_d   = 1'b1;
          end else if (in_byte_i == 8'd0) begin
            phase_d = PH_HUNT;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          ram_we  = 1'b1;
          sum_d   = sum_next;
          taken_d = taken_next;
          if (taken_next >= len_q) begin
            phase_d    = PH_HUNT;
            byte_idx_d = '0;
            grp_d      = '0;
            if (sum_next == exp_q) begin
              if (len_q == 8'd2) begin
                order_d      = 1'b1;
                words_left_d = WcntW'(1);
                phase_d      = PH_READ;
              end else if (words_cap != '0) begin
                order_d      = 1'b0;
                words_left_d = words_cap;
                phase_d      = PH_READ;
              end
            end
          end
        end
      end
      PH_READ: begin
        ram_re  = 1'b1;
        phase_d = PH_CAPT;
      end
      PH_CAPT: begin
        asm_d[grp_q*8 +: 8] = ram_rdata;
        byte_idx_d = byte_idx_q + AddrW'(1);
        grp_d      = grp_q + 2'd1;
        if ((order_q && grp_q == 2'd1) || grp_q == 2'd3) begin
          phase_d = PH_PUSH;
        end else begin
          phase_d = PH_READ;
        end
      end
      PH_PUSH: begin
        if (out_free) begin
          out_load     = 1'b1;
          kind_d       = order_q ? KIND_ORDER : KIND_WORD;
          word_d       = order_q ? 32'd0 : asm_q;
          first_d      = order_q ? asm_q[7:0] : 8'd0;
          second_d     = order_q ? asm_q[15:8] : 8'd0;
          last_d       = (words_left_q == WcntW'(1));
          words_left_d = words_left_q - WcntW'(1);
          grp_d        = '0;
          phase_d      = (words_left_q == WcntW'(1)) ? PH_HUNT : PH_READ;
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      sync_q       <= '0;
      hdr_cnt_q    <= 1'b0;
      exp_q        <= '0;
      len_q        <= '0;
      sum_q        <= '0;
      taken_q      <= '0;
      order_q      <= 1'b0;
      words_left_q <= '0;
      byte_idx_q   <= '0;
      grp_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      if (cfg_we_i) begin
        sync_q <= cfg_wdata_i;
      end
      hdr_cnt_q    <= hdr_cnt_d;
      exp_q        <= exp_d;
      len_q        <= len_d;
      sum_q        <= sum_d;
      taken_q      <= taken_d;
      order_q      <= order_d;
      words_left_q <= words_left_d;
      byte_idx_q   <= byte_idx_d;
      grp_q        <= grp_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // data path, no reset needed
  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
    if (out_load) begin
      kind_q   <= kind_d;
      word_q   <= word_d;
      first_q  <= first_d;
      second_q <= second_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign data_word_o    = word_q;
  assign order_first_o  = first_q;
  assign order_second_o = second_q;
  assign last_o         = last_q;

`ifndef SYNTH
  // a beat never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output beat overwritten");

  // readout always has a word to give
  a_words_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_READ || phase_q == PH_CAPT || phase_q == PH_PUSH)
      |-> words_left_q != '0)
    else $error("readout with no words left");

  // the final beat of a frame returns the block to hunting
  a_last_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PUSH && out_load && last_d) |=> phase_q == PH_HUNT)
    else $error("no return to hunt after last beat");

  // an oversize beat is always marked last
  a_oversize_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_OVERSIZE) |-> last_q)
    else $error("oversize beat not marked last");

  // capture only follows a ram read
  a_capt_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CAPT |-> $past(ram_re))
    else $error("capture without a read");
`endif

endmodule

// ===== tb/sync_length_checksum_deframer_unit_test.sv =====
// testbench for sync_length_checksum_deframer_unit: byte frames in, checked result beats out
// depends on slcd_pkg and the deframer rtl; self-checking, no external files
`timescale 1ns / 1ps

module sync_length_checksum_deframer_unit_test;
  import slcd_pkg::*;

  localparam int unsigned PayloadMax = 64;
  localparam int unsigned IdleWait   = 200;
  localparam int unsigned TimeoutNs  = 10_000_000;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] word;
    logic [7:0]  first;
    logic [7:0]  second;
    logic        last;
  } deframe_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] data_word_o;
  logic [7:0]  order_first_o;
  logic [7:0]  order_second_o;
  logic        last_o;

  sync_length_checksum_deframer_unit #(
    .MAX_PAYLOAD_BYTES(PayloadMax)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .data_word_o   (data_word_o),
    .order_first_o (order_first_o),
    .order_second_o(order_second_o),
    .last_o        (last_o)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #(TimeoutNs);
    $display("Test completed with failures");
    $finish;
  end

  // stimulus and scoreboard
  logic [7:0]      byte_q[$];
  logic [7:0]      frame_body[$];
  deframe_result_t expected_beats[$];
  int unsigned     fail_count = 0;

  // deframer state as the testbench sees it
  logic [7:0] sync_cfg = 8'h00;
  phase_e     hunt_phase = PH_HUNT;
  logic [1:0] hdr_seen = 2'd0;
  logic [7:0] want_sum = 8'h00;
  logic [7:0] frame_len = 8'h00;
  logic [7:0] sum_acc = 8'h00;
  logic [7:0] taken = 8'h00;
  logic [7:0] payload_mem[PayloadMax];

  function automatic void close_frame();
    deframe_result_t r;
    int unsigned words;
    int unsigned i;
    hunt_phase = PH_HUNT;
    if (sum_acc != want_sum) return;
    r = '0;
    if (frame_len == 8'd2) begin
      r.kind = KIND_ORDER;
      r.first = payload_mem[0];
      r.second = payload_mem[1];
      r.last = 1'b1;
      expected_beats.push_back(r);
    end else if (frame_len > 8'd2) begin
      words = frame_len / 4;
      if (words > MaxResults) words = MaxResults;
      for (i = 0; i < words; i++) begin
        r.kind = KIND_WORD;
        r.word = {payload_mem[4*i+3], payload_mem[4*i+2], payload_mem[4*i+1], payload_mem[4*i]};
        r.last = (i + 1 == words);
        expected_beats.push_back(r);
      end
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    deframe_result_t r;
    r = '0;
    case (hunt_phase)
      PH_HUNT: begin
        if (b == sync_cfg) begin
          hunt_phase = PH_HEADER;
          hdr_seen = 2'd0;
        end
      end
      PH_HEADER: begin
        hdr_seen = hdr_seen + 2'd1;
        if (hdr_seen >= HeaderBytes) hunt_phase = PH_CHECK;
      end
      PH_CHECK: begin
        want_sum = b;
        hunt_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        frame_len = b;
        sum_acc = b;
        taken = 8'h00;
        if (b > PayloadMax) begin
          hunt_phase = PH_HUNT;
          r.kind = KIND_OVERSIZE;
          r.last = 1'b1;
          expected_beats.push_back(r);
        end else if (b == 8'h00) begin
          close_frame();
        end else begin
          hunt_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (taken < PayloadMax) payload_mem[taken] = b;
        sum_acc = sum_acc + b;
        taken = taken + 8'd1;
        if (taken >= frame_len) close_frame();
      end
      default: hunt_phase = PH_HUNT;
    endcase
  endfunction

  // queue one frame around frame_body; cut drops bytes from the end of the body
  task automatic push_frame(input logic [7:0] hdr_a, input logic [7:0] hdr_b,
                            input logic [7:0] len, input bit corrupt,
                            input int unsigned cut, inout int unsigned made);
    logic [7:0] sum;
    int unsigned i;
    sum = len;
    foreach (frame_body[k]) sum = sum + frame_body[k];
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    byte_q.push_back(sync_cfg);
    byte_q.push_back(hdr_a);
    byte_q.push_back(hdr_b);
    byte_q.push_back(sum);
    byte_q.push_back(len);
    made += 5;
    if (len <= PayloadMax) begin
      for (i = 0; i + cut < frame_body.size(); i++) byte_q.push_back(frame_body[i]);
      made += frame_body.size() - cut;
    end
  endtask

  task automatic fill_body(input int unsigned len);
    int unsigned i;
    frame_body.delete();
    for (i = 0; i < len && i < PayloadMax; i++) frame_body.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic random_frames(input int unsigned target);
    int unsigned made;
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    logic [7:0] b;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // line noise that never looks like a sync byte
        for (n = $urandom_range(1, 4); n > 0; n--) begin
          b = 8'($urandom_range(0, 255));
          if (b == sync_cfg) b = b ^ 8'h01;
          byte_q.push_back(b);
        end
      end else if (pick < 18) begin
        len = $urandom_range(0, 64);
        if ($urandom_range(0, 1)) len = $urandom_range(0, 6);
        fill_body(len);
        push_frame(8'($urandom), 8'($urandom), 8'(len), 1'b1, 0, made);
      end else if (pick < 25) begin
        n = $urandom_range(0, 3);
        len = (n == 0) ? 65 : (n == 1) ? 255 : $urandom_range(66, 254);
        frame_body.delete();
        push_frame(8'($urandom), 8'($urandom), 8'(len), 1'b0, 0, made);
      end else if (pick < 30) begin
        // frame cut short, the next bytes run into it
        len = $urandom_range(2, 16);
        fill_body(len);
        push_frame(8'($urandom), 8'($urandom), 8'(len), 1'b0, $urandom_range(1, len), made);
      end else begin
        n = $urandom_range(0, 99);
        if (n < 10) len = $urandom_range(0, 3);
        else if (n < 20) len = 64;
        else if (n < 26) len = $urandom_range(60, 63);
        else len = $urandom_range(4, 24);
        fill_body(len);
        push_frame(8'($urandom), 8'($urandom), 8'(len), 1'b0, 0, made);
      end
    end
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    sync_cfg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i <= 8'h00;
    end else begin
      if (in_valid_i && in_ready_o) deframe_byte(in_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_byte_i <= byte_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: randomly chosen stall modes: always ready, periodic, random or stalled
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned rx_tick = 0;
  deframe_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: kind %0d word %h order %h/%h last %b",
                 kind_o, data_word_o, order_first_o, order_second_o, last_o);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_o);
            fail_count++;
          end
          if (data_word_o !== want.word) begin
            $error("data_word: expected %h, got %h", want.word, data_word_o);
            fail_count++;
          end
          if (order_first_o !== want.first) begin
            $error("order_first: expected %h, got %h", want.first, order_first_o);
            fail_count++;
          end
          if (order_second_o !== want.second) begin
            $error("order_second: expected %h, got %h", want.second, order_second_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %b, got %b", want.last, last_o);
            fail_count++;
          end
        end
      end
      rx_tick++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = (stall_mode == 3) ? $urandom_range(5, 30) : $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= (rx_tick % 3 == 0);
        2: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= 1'b0;
      endcase
    end
  end

  int unsigned directed_made;

  initial begin
    directed_made = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames with the reset sync byte of zero
    // order pair, header bytes equal to the sync value
    frame_body.delete();
    frame_body.push_back(8'hFF);
    frame_body.push_back(8'h00);
    push_frame(8'h00, 8'h00, 8'd2, 1'b0, 0, directed_made);
    // empty frame
    frame_body.delete();
    push_frame(8'hFF, 8'h12, 8'd0, 1'b0, 0, directed_made);
    // one past the largest payload
    push_frame(8'h34, 8'hFF, 8'd65, 1'b0, 0, directed_made);
    // single byte with a bad checksum
    frame_body.push_back(8'h5A);
    push_frame(8'h01, 8'h02, 8'd1, 1'b1, 0, directed_made);
    // one word with extreme bytes and the sync value inside
    frame_body.delete();
    frame_body.push_back(8'hFF);
    frame_body.push_back(8'h00);
    frame_body.push_back(8'hA5);
    frame_body.push_back(8'h5A);
    push_frame(8'h80, 8'h7F, 8'd4, 1'b0, 0, directed_made);
    wait_idle();

    write_sync(8'hFF);
    random_frames(75);
    wait_idle();

    write_sync(8'($urandom_range(1, 254)));
    random_frames(75);
    wait_idle();

    write_sync(8'h00);
    random_frames(70);
    wait_idle();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
